// ===== rtl/core/csq_pkg.sv =====
// Shared constants and types for the 2x2 chi-square statistic core.
package csq_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int STAT_WIDTH      = 34;

    localparam int CFG_ADDR_WIDTH  = 3;
    localparam logic CFG_IDX_YATES = 1'b0;

    typedef struct packed {
        logic sat;
        logic undef;
    } t_flags;

endpackage

// ===== rtl/core/csq_front.sv =====
// Multiply pipeline that forms the numerator and denominator of the statistic.
module csq_front
    import csq_pkg::*;
#(
    parameter int CW = COUNT_WIDTH_DEF,
    parameter int F  = FRAC_BITS_DEF,
    parameter int QW = STAT_WIDTH,
    parameter int DW = 4 * (CW + 1) + 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [CW-1:0] i_a,
    input  logic [CW-1:0] i_b,
    input  logic [CW-1:0] i_c,
    input  logic [CW-1:0] i_d,
    input  logic          i_yates,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [DW-1:0] o_rem,
    output logic [QW-1:0] o_bits,
    output logic [DW-1:0] o_den,
    output t_flags        o_flags
);

    localparam int MW   = CW + 1;
    localparam int NW   = CW + 2;
    localparam int PW   = 2 * CW;
    localparam int AW   = 2 * CW + 1;
    localparam int NUMW = 2 * AW + NW + F;
    localparam int NX   = (NUMW > QW + DW + 1) ? NUMW : QW + DW + 1;
    localparam int HW   = NX - QW;

    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    logic [PW-1:0]   r_p1, r_p2;
    logic [MW-1:0]   r_m1, r_m2, r_m3, r_m4;
    logic [NW-1:0]   r_n1;
    logic            r_y1, r_u1;

    logic [AW-1:0]   r_aa2;
    logic [NW-1:0]   r_n2;
    logic [2*MW-1:0] r_mm12, r_mm34;
    logic            r_u2;

    logic [2*AW-1:0] r_sq;
    logic [NW-1:0]   r_n3;
    logic [3*MW-1:0] r_den_lo, r_den_hi;
    logic            r_u3;

    logic [AW+NW-1:0] r_num_lo, r_num_hi;
    logic [DW-1:0]   r_den4;
    logic            r_u4;

    logic [DW-1:0]   r_rem5, r_den5;
    logic [QW-1:0]   r_bits5;
    t_flags          r_f5;

    logic [MW-1:0]   w_m1, w_m2, w_m3, w_m4;
    logic [PW-1:0]   w_d;
    logic [AW-1:0]   w_diff2, w_k2;
    logic [NX-1:0]   w_num;
    logic [HW-1:0]   w_hi;

    assign rdy5    = !r_v5 || i_ready;
    assign rdy4    = !r_v4 || rdy5;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    assign w_m1 = MW'(i_a) + MW'(i_b);
    assign w_m2 = MW'(i_c) + MW'(i_d);
    assign w_m3 = MW'(i_a) + MW'(i_c);
    assign w_m4 = MW'(i_b) + MW'(i_d);

    assign w_d     = (r_p1 > r_p2) ? (r_p1 - r_p2) : (r_p2 - r_p1);
    assign w_diff2 = {w_d, 1'b0};
    assign w_k2    = r_y1 ? AW'(r_n1) : '0;

    assign w_num = ((NX'(r_num_hi) << AW) + NX'(r_num_lo)) << F;
    assign w_hi  = w_num[NX-1:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_p1 <= PW'(i_a) * PW'(i_d);
            r_p2 <= PW'(i_b) * PW'(i_c);
            r_m1 <= w_m1;
            r_m2 <= w_m2;
            r_m3 <= w_m3;
            r_m4 <= w_m4;
            r_n1 <= NW'(w_m1) + NW'(w_m2);
            r_y1 <= i_yates;
            r_u1 <= (w_m1 == '0) || (w_m2 == '0) || (w_m3 == '0) || (w_m4 == '0);
        end
        if (rdy2 && r_v1) begin
            r_aa2  <= (w_diff2 > w_k2) ? (w_diff2 - w_k2) : '0;
            r_n2   <= r_n1;
            r_mm12 <= (2*MW)'(r_m1) * (2*MW)'(r_m2);
            r_mm34 <= (2*MW)'(r_m3) * (2*MW)'(r_m4);
            r_u2   <= r_u1;
        end
        if (rdy3 && r_v2) begin
            r_sq     <= (2*AW)'(r_aa2) * (2*AW)'(r_aa2);
            r_n3     <= r_n2;
            r_den_lo <= (3*MW)'(r_mm12) * (3*MW)'(r_mm34[MW-1:0]);
            r_den_hi <= (3*MW)'(r_mm12) * (3*MW)'(r_mm34[2*MW-1:MW]);
            r_u3     <= r_u2;
        end
        if (rdy4 && r_v3) begin
            r_num_lo <= (AW+NW)'(r_sq[AW-1:0]) * (AW+NW)'(r_n3);
            r_num_hi <= (AW+NW)'(r_sq[2*AW-1:AW]) * (AW+NW)'(r_n3);
            r_den4   <= ((DW'(r_den_hi) << MW) + DW'(r_den_lo)) << 2;
            r_u4     <= r_u3;
        end
        if (rdy5 && r_v4) begin
            r_rem5      <= w_hi[DW-1:0];
            r_bits5     <= w_num[QW-1:0];
            r_den5      <= r_den4;
            r_f5.sat    <= (w_hi >= HW'(r_den4));
            r_f5.undef  <= r_u4;
        end
    end

    assign o_valid = r_v5;
    assign o_rem   = r_rem5;
    assign o_bits  = r_bits5;
    assign o_den   = r_den5;
    assign o_flags = r_f5;

endmodule

// ===== rtl/core/csq_div_cell.sv =====
// One restoring-division cell that resolves a single quotient bit.
module csq_div_cell
    import csq_pkg::*;
#(
    parameter int DW = 4 * (COUNT_WIDTH_DEF + 1) + 2,
    parameter int QW = STAT_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_bits,
    input  logic [QW-1:0] i_q,
    input  logic [DW-1:0] i_den,
    input  t_flags        i_flags,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [DW-1:0] o_rem,
    output logic [QW-1:0] o_bits,
    output logic [QW-1:0] o_q,
    output logic [DW-1:0] o_den,
    output t_flags        o_flags
);

    logic          r_v;
    logic [DW-1:0] r_rem, r_den;
    logic [QW-1:0] r_bits, r_q;
    t_flags        r_f;
    logic [DW:0]   w_rem2, w_sub;
    logic          w_ge;
    logic          rdy;

    assign rdy     = !r_v || i_ready;
    assign o_ready = rdy;

    assign w_rem2 = {i_rem, i_bits[QW-1]};
    assign w_sub  = w_rem2 - {1'b0, i_den};
    assign w_ge   = (w_rem2 >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy && i_valid) begin
            r_rem  <= w_ge ? w_sub[DW-1:0] : w_rem2[DW-1:0];
            r_bits <= i_bits << 1;
            r_q    <= {i_q[QW-2:0], w_ge};
            r_den  <= i_den;
            r_f    <= i_flags;
        end
    end

    assign o_valid = r_v;
    assign o_rem   = r_rem;
    assign o_bits  = r_bits;
    assign o_q     = r_q;
    assign o_den   = r_den;
    assign o_flags = r_f;

endmodule

// ===== rtl/core/chi_square_2x2_statistic_core.sv =====
// Top level of the pipelined 2x2 chi-square statistic core.
//
// Channel   Direction  Handshake                      Payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready  four counts in tdata
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready  statistic in tdata, undefined in tuser
// apb       in         psel/penable/pwrite/pready      Yates enable bit at addresses 0 to 3
//
// One word is accepted per cycle while the output is not stalled. The pipeline holds five
// multiply stages, one division cell per quotient bit (34), and the output register.
// Each full stage holds when its successor cannot accept, so bubbles are squeezed out on a stall.
// Reset is synchronous and clears the valid bits and the Yates register.
module chi_square_2x2_statistic_core
    import csq_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // count_major_a, count_major_b, count_minor_a, count_minor_b
    input  logic [((4*COUNT_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // statistic
    output logic [((STAT_WIDTH+7)/8)*8-1:0] o_m_axis_tdata,
    // undefined
    output logic                          o_m_axis_tuser,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [CFG_ADDR_WIDTH-1:0]     paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int CW  = COUNT_WIDTH;
    localparam int QW  = STAT_WIDTH;
    localparam int DW  = 4 * (CW + 1) + 2;
    localparam int OTW = ((QW + 7) / 8) * 8;

    logic r_yates;

    logic          v   [QW+1];
    logic          rdy [QW+1];
    logic [DW-1:0] rem [QW+1];
    logic [QW-1:0] bts [QW+1];
    logic [QW-1:0] q   [QW+1];
    logic [DW-1:0] den [QW+1];
    t_flags        fl  [QW+1];

    logic          r_ov;
    logic [QW-1:0] r_stat;
    logic          r_undef;
    logic          out_rdy;

    assign pready = 1'b1;
    assign prdata = {31'b0, r_yates};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yates <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && paddr[CFG_ADDR_WIDTH-1] == CFG_IDX_YATES) begin
            r_yates <= pwdata[0];
        end
    end

    csq_front #(
        .CW (CW),
        .F  (FRAC_BITS),
        .QW (QW),
        .DW (DW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_a     (i_s_axis_tdata[CW-1:0]),
        .i_b     (i_s_axis_tdata[2*CW-1:CW]),
        .i_c     (i_s_axis_tdata[3*CW-1:2*CW]),
        .i_d     (i_s_axis_tdata[4*CW-1:3*CW]),
        .i_yates (r_yates),
        .o_valid (v[0]),
        .i_ready (rdy[0]),
        .o_rem   (rem[0]),
        .o_bits  (bts[0]),
        .o_den   (den[0]),
        .o_flags (fl[0])
    );

    assign q[0] = '0;

    for (genvar g = 0; g < QW; g++) begin : g_cell
        csq_div_cell #(
            .DW (DW),
            .QW (QW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[g]),
            .o_ready (rdy[g]),
            .i_rem   (rem[g]),
            .i_bits  (bts[g]),
            .i_q     (q[g]),
            .i_den   (den[g]),
            .i_flags (fl[g]),
            .o_valid (v[g+1]),
            .i_ready (rdy[g+1]),
            .o_rem   (rem[g+1]),
            .o_bits  (bts[g+1]),
            .o_q     (q[g+1]),
            .o_den   (den[g+1]),
            .o_flags (fl[g+1])
        );
    end

    assign out_rdy = !r_ov || i_m_axis_tready;
    assign rdy[QW] = out_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_rdy) begin
            r_ov <= v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy && v[QW]) begin
            r_undef <= fl[QW].undef;
            if (fl[QW].undef) begin
                r_stat <= '0;
            end else if (fl[QW].sat) begin
                r_stat <= '1;
            end else begin
                r_stat <= q[QW];
            end
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = OTW'(r_stat);
    assign o_m_axis_tuser  = r_undef;

endmodule

// ===== bench/tb_chi_square_2x2_statistic_core.sv =====
// Self-checking bench for the 2x2 chi-square core: random and corner tables, checked per word.
`timescale 1ns / 100ps

class chi_square_tracker;
    logic [33:0] stat_q[$];
    logic        undef_q[$];
    bit          yates;
    int          errors;

    function logic [33:0] compute_stat(logic [15:0] a, logic [15:0] b,
                                       logic [15:0] c, logic [15:0] d,
                                       output logic undef);
        logic [17:0]  n;
        logic [16:0]  m1, m2, m3, m4;
        logic [31:0]  p1, p2;
        logic [33:0]  diff2, aa2;
        logic [255:0] num, den, quo;
        m1 = a + b;
        m2 = c + d;
        m3 = a + c;
        m4 = b + d;
        n = m1 + m2;
        undef = 1'b0;
        if (m1 == 0 || m2 == 0 || m3 == 0 || m4 == 0) begin
            undef = 1'b1;
            return '0;
        end
        p1 = a * d;
        p2 = b * c;
        diff2 = (p1 > p2) ? {1'b0, p1 - p2, 1'b0} : {1'b0, p2 - p1, 1'b0};
        if (yates)
            aa2 = (diff2 > n) ? diff2 - n : '0;
        else
            aa2 = diff2;
        num = 256'(n) * 256'(aa2) * 256'(aa2);
        num = num << 16;
        den = (256'(m1) * 256'(m2) * 256'(m3) * 256'(m4)) << 2;
        quo = num / den;
        if (quo >= (256'd1 << 34))
            return {34{1'b1}};
        return quo[33:0];
    endfunction

    function void note_table(logic [63:0] word);
        logic        u;
        logic [33:0] s;
        s = compute_stat(word[15:0], word[31:16], word[47:32], word[63:48], u);
        stat_q.push_back(s);
        undef_q.push_back(u);
    endfunction

    function void check_result(logic [33:0] stat, logic undef);
        logic [33:0] es;
        logic        eu;
        if (stat_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("Unexpected result word: stat=%0d undef=%0b", stat, undef);
            return;
        end
        es = stat_q.pop_front();
        eu = undef_q.pop_front();
        if (es !== stat || eu !== undef) begin
            errors++;
            if (errors <= 10)
                $display("Mismatch: expected stat=%0d undef=%0b, got stat=%0d undef=%0b",
                         es, eu, stat, undef);
        end
    endfunction
endclass

module tb_chi_square_2x2_statistic_core;
    import csq_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [39:0] m_data;
    logic        m_user;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [CFG_ADDR_WIDTH-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    chi_square_tracker tracker;
    bit hold_off = 1'b0;
    bit done = 1'b0;
    int idle_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    chi_square_2x2_statistic_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready), .i_s_axis_tdata(s_data),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    function int pick_gap();
        if ($urandom_range(0, 3) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    function logic [15:0] pick_count();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 15));
            3: return 16'($urandom_range(0, 300));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_yates(input bit value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_WIDTH'(CFG_IDX_YATES) << 2;
        pwdata <= {31'b0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        tracker.yates = value;
    endtask

    task automatic send_table(input logic [63:0] word, input int gap);
        repeat (gap) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= word;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        tracker.note_table(word);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.stat_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic run_random(input int count, input bit gaps);
        for (int k = 0; k < count; k++)
            send_table({pick_count(), pick_count(), pick_count(), pick_count()},
                       gaps ? pick_gap() : 0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready)
            tracker.check_result(m_data[33:0], m_user);
    end

    initial begin
        int gap;
        wait (i_rst_n);
        forever begin
            gap = hold_off ? 0 : pick_gap();
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (gap == 0 || $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (!done && idle_cycles > 5000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        logic [63:0] corners[$];
        tracker = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        corners = '{64'h0, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
                    {16'd0, 16'd0, 16'd5, 16'd7}, {16'd3, 16'd0, 16'd4, 16'd0},
                    {16'hFFFF, 16'd0, 16'd0, 16'hFFFF}, {16'd0, 16'hFFFF, 16'hFFFF, 16'd0},
                    {16'd1, 16'd1, 16'd1, 16'd1}, {16'd10, 16'd11, 16'd12, 16'd13},
                    {16'd1, 16'd0, 16'd0, 16'd1}, {16'hFFFF, 16'd1, 16'd1, 16'hFFFF},
                    {16'd5, 16'd9, 16'd9, 16'd5}, {16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA}};
        foreach (corners[k]) send_table(corners[k], 0);
        drain();
        write_yates(1'b1);
        foreach (corners[k]) send_table(corners[k], pick_gap());
        drain();
        write_yates(1'b0);
        run_random(600, 1'b1);
        hold_off = 1'b1;
        run_random(200, 1'b0);
        drain();
        write_yates(1'b1);
        run_random(700, 1'b1);
        drain();
        write_yates(1'b0);
        run_random(500, 1'b1);
        drain();

        done = 1'b1;
        if (tracker.errors == 0 && tracker.stat_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
